>>> hw/rtl/solar_tracker_step_controller_macros.svh
// Assertion macros for the solar tracker checker file.
`ifndef SOLAR_TRACKER_STEP_CONTROLLER_MACROS_SVH
`define SOLAR_TRACKER_STEP_CONTROLLER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define STC_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define STC_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/stc_pkg.sv
// Shared widths, codes and reset values of the solar tracker step controller.
package stc_pkg;

    localparam int unsigned STEP_W    = 8;
    localparam int unsigned LUX_W     = 16;
    localparam int unsigned SUM_W     = LUX_W + 1;
    localparam int unsigned MV_W      = 15;
    localparam int unsigned ROLL_W    = 16;
    localparam int unsigned ERR_W     = 16;
    localparam int unsigned STATUS_W  = 4;
    localparam int unsigned OP_W      = 2;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DAT_W = 17;
    localparam int unsigned IN_DATA_W = 64;
    localparam int unsigned OUT_DATA_W = 32;

    // Divider: quotient of (diff << 15) / sum
    localparam int unsigned DIV_Q_W   = 16;
    localparam int unsigned DIV_R_W   = SUM_W + 1;

    localparam logic [STEP_W-1:0] MAX_STEPS_DEF  = 8'd200;
    localparam logic [STEP_W-1:0] HOME_STEPS_DEF = 8'd20;

    typedef logic signed [ERR_W-1:0] q15_t;

    // Opcodes
    localparam logic [OP_W-1:0] OP_TICK  = 2'd0;
    localparam logic [OP_W-1:0] OP_TRACK = 2'd1;
    localparam logic [OP_W-1:0] OP_CHECK = 2'd2;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_HOMING    = 4'd0;
    localparam logic [STATUS_W-1:0] ST_ALIGNED   = 4'd1;
    localparam logic [STATUS_W-1:0] ST_DARK      = 4'd2;
    localparam logic [STATUS_W-1:0] ST_LIMIT     = 4'd3;
    localparam logic [STATUS_W-1:0] ST_WAIT      = 4'd4;
    localparam logic [STATUS_W-1:0] ST_STABLE    = 4'd5;
    localparam logic [STATUS_W-1:0] ST_DEADZONE  = 4'd6;
    localparam logic [STATUS_W-1:0] ST_MOVING    = 4'd7;
    localparam logic [STATUS_W-1:0] ST_EFFECTIVE = 4'd8;
    localparam logic [STATUS_W-1:0] ST_REVERTED  = 4'd9;
    localparam logic [STATUS_W-1:0] ST_BUSY      = 4'd10;
    localparam logic [STATUS_W-1:0] ST_NOCHECK   = 4'd11;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEADZONE  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CHANGE    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_VGAIN = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ROLL_LIM  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_HOME_TOL  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_NIGHT_LUX = 3'd7;

    // Register reset values
    localparam logic [15:0] GAIN_RST      = 16'd800;
    localparam logic [14:0] DEADZONE_RST  = 15'd1638;
    localparam logic [14:0] CHANGE_RST    = 15'd3277;
    localparam logic [14:0] MIN_VGAIN_RST = 15'd50;
    localparam logic [14:0] ROLL_LIM_RST  = 15'd4500;
    localparam logic [14:0] HOME_TOL_RST  = 15'd100;
    localparam logic [15:0] INTERVAL_RST  = 16'd600;
    localparam logic [16:0] NIGHT_LUX_RST = 17'd50;

endpackage

>>> hw/rtl/stc_div.sv
// Restoring serial divider: one quotient bit per cycle for the lux error ratio.
module stc_div (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [stc_pkg::LUX_W-1:0]     dividend,
    input  logic [stc_pkg::SUM_W-1:0]     divisor,
    output logic                          done,
    output logic [stc_pkg::DIV_Q_W-1:0]   quotient
);
    import stc_pkg::*;

    localparam int unsigned CNT_W = $clog2(DIV_Q_W);

    logic                 busy_reg;
    logic                 done_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic [DIV_R_W-1:0]   rem_reg;
    logic [DIV_Q_W-1:0]   quot_reg;
    logic                 q_bit;
    logic [DIV_R_W-1:0]   rem_sub;

    assign q_bit   = rem_reg >= {1'b0, divisor};
    assign rem_sub = q_bit ? rem_reg - {1'b0, divisor} : rem_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(DIV_Q_W - 1);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Remainder stays below twice the divisor, so the shift never overflows.
    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg  <= {2'b00, dividend};
            quot_reg <= '0;
        end else if (busy_reg) begin
            rem_reg  <= {rem_sub[DIV_R_W-2:0], 1'b0};
            quot_reg <= {quot_reg[DIV_Q_W-2:0], q_bit};
        end
    end

    assign done     = done_reg;
    assign quotient = quot_reg;

endmodule

>>> hw/rtl/solar_tracker_step_controller.sv
// Solar tracker step controller top level: sequencer, state and output register.
// A tracking sample that runs the divider passes S_EVAL, S_DIV, S_CHK, S_MUL, S_MOVE, S_FIN
// (S_CHK goes to S_FIN when stable or in the deadzone); in S_DIV the divider forms 16 quotient
// bits, then pulses done. Post-move samples and early-exit tracking samples go S_EVAL to S_FIN;
// S_FIN waits for a free output. One item is in flight at a time; s_tready returns with m_tvalid.
// aresetn (synchronous, active low) restores register defaults and clears tracker state.
module solar_tracker_step_controller #(
    parameter logic [stc_pkg::STEP_W-1:0] MAX_STEPS  = stc_pkg::MAX_STEPS_DEF,
    parameter logic [stc_pkg::STEP_W-1:0] HOME_STEPS = stc_pkg::HOME_STEPS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // left_lux[15:0], right_lux[31:16], bus_mv[46:32], roll_cdeg[62:47], zero[63]
    input  logic [stc_pkg::IN_DATA_W-1:0]     s_tdata,
    // opcode[1:0]
    input  logic [stc_pkg::OP_W-1:0]          s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // move[0], step_count[8:1], direction[9], error_q15[25:10], zero[31:26]
    output logic [stc_pkg::OUT_DATA_W-1:0]    m_tdata,
    // status[3:0]
    output logic [stc_pkg::STATUS_W-1:0]      m_tuser,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [stc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [stc_pkg::CFG_DAT_W-1:0]     cfg_data
);
    import stc_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EVAL = 3'd1;
    localparam logic [2:0] S_DIV  = 3'd2;
    localparam logic [2:0] S_CHK  = 3'd3;
    localparam logic [2:0] S_MUL  = 3'd4;
    localparam logic [2:0] S_MOVE = 3'd5;
    localparam logic [2:0] S_FIN  = 3'd6;

    logic [2:0] state_reg, state_next;

    // Configuration
    logic [15:0] gain_reg;
    logic [14:0] deadzone_reg;
    logic [14:0] change_reg;
    logic [14:0] min_vgain_reg;
    logic [14:0] roll_lim_reg;
    logic [14:0] home_tol_reg;
    logic [15:0] interval_reg;
    logic [16:0] night_lux_reg;

    // Tracker state
    logic              aligned_reg;
    q15_t              last_error_reg;
    logic [15:0]       ssm_reg;
    logic              pending_reg;
    logic [STEP_W-1:0] pend_steps_reg;
    logic              pend_dir_reg;
    q15_t              pend_err_reg;
    logic [MV_W-1:0]   volt_before_reg;

    // Captured item
    logic [OP_W-1:0]   op_reg;
    logic [LUX_W-1:0]  left_reg;
    logic [LUX_W-1:0]  right_reg;
    logic [MV_W-1:0]   bus_reg;
    logic [ROLL_W-1:0] roll_reg;

    // Working values
    q15_t              err_reg;
    logic [ERR_W-1:0]  err_abs_reg;
    logic [31:0]       prod_reg;

    // Staged result
    logic                res_move_reg;
    logic [STEP_W-1:0]   res_steps_reg;
    logic                res_dir_reg;
    logic [STATUS_W-1:0] res_status_reg;
    q15_t                res_err_reg;

    // Output register
    logic                  m_valid_reg;
    logic [OUT_DATA_W-1:0] m_data_reg;
    logic [STATUS_W-1:0]   m_user_reg;

    logic                 in_beat;
    logic [SUM_W-1:0]     lux_sum;
    logic [LUX_W-1:0]     lux_diff;
    logic                 right_ge;
    logic [ROLL_W-1:0]    roll_abs;
    logic                 roll_pos;
    logic signed [MV_W:0] volt_rise;
    logic                 volt_short;
    logic                 div_start;
    logic                 div_done;
    logic [DIV_Q_W-1:0]   div_quot;
    q15_t                 err_calc;
    logic [ERR_W:0]       err_delta;
    logic [ERR_W:0]       err_delta_abs;
    logic [ERR_W-1:0]     err_calc_abs;
    logic                 is_stable;
    logic                 is_deadzone;
    logic [16:0]          prod_steps;
    logic [STEP_W-1:0]    move_steps;
    logic                 move_dir;
    logic                 out_free;

    assign in_beat  = s_tvalid && s_tready;
    assign s_tready = state_reg == S_IDLE;
    assign cfg_ready = 1'b1;

    assign lux_sum  = {1'b0, left_reg} + {1'b0, right_reg};
    assign right_ge = right_reg >= left_reg;
    assign lux_diff = right_ge ? right_reg - left_reg : left_reg - right_reg;
    assign roll_abs = roll_reg[ROLL_W-1] ? (~roll_reg + 1'b1) : roll_reg;
    assign roll_pos = !roll_reg[ROLL_W-1] && (roll_reg != '0);
    assign volt_rise  = $signed({1'b0, bus_reg}) - $signed({1'b0, volt_before_reg});
    assign volt_short = volt_rise < $signed({1'b0, min_vgain_reg});

    assign div_start = (state_reg == S_EVAL) && (op_reg == OP_TRACK) && !pending_reg
                       && aligned_reg && (lux_sum >= night_lux_reg)
                       && ({1'b0, roll_abs} <= {2'b00, roll_lim_reg})
                       && (ssm_reg >= interval_reg);

    stc_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (lux_diff),
        .divisor  (lux_sum),
        .done     (div_done),
        .quotient (div_quot)
    );

    // Sign and clamp the quotient; an all-dark pair gives zero error.
    always_comb begin
        if (lux_sum == '0) begin
            err_calc = '0;
        end else if (right_ge) begin
            err_calc = div_quot[DIV_Q_W-1] ? q15_t'(16'sh7FFF) : q15_t'(div_quot);
        end else begin
            err_calc = q15_t'(~div_quot + 1'b1);
        end
    end

    assign err_delta     = {err_calc[ERR_W-1], err_calc}
                           - {last_error_reg[ERR_W-1], last_error_reg};
    assign err_delta_abs = err_delta[ERR_W] ? (~err_delta + 1'b1) : err_delta;
    assign err_calc_abs  = err_calc[ERR_W-1] ? (~err_calc + 1'b1) : err_calc;
    assign is_stable     = err_delta_abs < {2'b00, change_reg};
    assign is_deadzone   = err_calc_abs < {1'b0, deadzone_reg};

    assign prod_steps = prod_reg[31:15];
    assign move_steps = (prod_steps > {9'd0, MAX_STEPS}) ? MAX_STEPS
                                                          : prod_steps[STEP_W-1:0];
    assign move_dir   = !err_reg[ERR_W-1] && (err_reg != '0);

    assign out_free = !m_valid_reg || m_tready;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (in_beat) begin
                    state_next = S_EVAL;
                end
            end
            S_EVAL: begin
                if (div_start) begin
                    state_next = S_DIV;
                end else if (op_reg == OP_TRACK || op_reg == OP_CHECK) begin
                    state_next = S_FIN;
                end else begin
                    state_next = S_IDLE;
                end
            end
            S_DIV: begin
                if (div_done) begin
                    state_next = S_CHK;
                end
            end
            S_CHK: begin
                state_next = (is_stable || is_deadzone) ? S_FIN : S_MUL;
            end
            S_MUL: begin
                state_next = S_MOVE;
            end
            S_MOVE: begin
                state_next = S_FIN;
            end
            S_FIN: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control, configuration and tracker state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_IDLE;
            m_valid_reg     <= 1'b0;
            gain_reg        <= GAIN_RST;
            deadzone_reg    <= DEADZONE_RST;
            change_reg      <= CHANGE_RST;
            min_vgain_reg   <= MIN_VGAIN_RST;
            roll_lim_reg    <= ROLL_LIM_RST;
            home_tol_reg    <= HOME_TOL_RST;
            interval_reg    <= INTERVAL_RST;
            night_lux_reg   <= NIGHT_LUX_RST;
            aligned_reg     <= 1'b0;
            last_error_reg  <= '0;
            ssm_reg         <= '0;
            pending_reg     <= 1'b0;
            pend_steps_reg  <= '0;
            pend_dir_reg    <= 1'b0;
            pend_err_reg    <= '0;
            volt_before_reg <= '0;
        end else begin
            state_reg <= state_next;

            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    CFG_GAIN:      gain_reg      <= cfg_data[15:0];
                    CFG_DEADZONE:  deadzone_reg  <= cfg_data[14:0];
                    CFG_CHANGE:    change_reg    <= cfg_data[14:0];
                    CFG_MIN_VGAIN: min_vgain_reg <= cfg_data[14:0];
                    CFG_ROLL_LIM:  roll_lim_reg  <= cfg_data[14:0];
                    CFG_HOME_TOL:  home_tol_reg  <= cfg_data[14:0];
                    CFG_INTERVAL:  interval_reg  <= cfg_data[15:0];
                    CFG_NIGHT_LUX: night_lux_reg <= cfg_data;
                    default: ;
                endcase
            end

            if (state_reg == S_EVAL) begin
                case (op_reg)
                    OP_TICK: begin
                        if (ssm_reg != 16'hFFFF) begin
                            ssm_reg <= ssm_reg + 1'b1;
                        end
                    end
                    OP_CHECK: begin
                        if (pending_reg) begin
                            pending_reg <= 1'b0;
                            if (!volt_short) begin
                                last_error_reg <= pend_err_reg;
                                ssm_reg        <= '0;
                            end
                        end
                    end
                    OP_TRACK: begin
                        if (!pending_reg && !aligned_reg
                            && ({1'b0, roll_abs} <= {2'b00, home_tol_reg})) begin
                            aligned_reg <= 1'b1;
                            ssm_reg     <= '0;
                        end
                    end
                    default: ;
                endcase
            end

            if (state_reg == S_MOVE) begin
                pending_reg     <= 1'b1;
                pend_steps_reg  <= move_steps;
                pend_dir_reg    <= move_dir;
                pend_err_reg    <= err_reg;
                volt_before_reg <= bus_reg;
            end

            // Hold the result until the sink takes the beat.
            if (state_reg == S_FIN && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (in_beat) begin
            op_reg    <= s_tuser;
            left_reg  <= s_tdata[15:0];
            right_reg <= s_tdata[31:16];
            bus_reg   <= s_tdata[46:32];
            roll_reg  <= s_tdata[62:47];
        end

        if (state_reg == S_EVAL) begin
            res_move_reg   <= 1'b0;
            res_steps_reg  <= '0;
            res_dir_reg    <= 1'b0;
            res_err_reg    <= '0;
            res_status_reg <= ST_NOCHECK;
            if (op_reg == OP_CHECK) begin
                if (pending_reg && volt_short) begin
                    res_move_reg   <= 1'b1;
                    res_steps_reg  <= pend_steps_reg;
                    res_dir_reg    <= !pend_dir_reg;
                    res_status_reg <= ST_REVERTED;
                    res_err_reg    <= pend_err_reg;
                end else if (pending_reg) begin
                    res_status_reg <= ST_EFFECTIVE;
                    res_err_reg    <= pend_err_reg;
                end
            end else if (pending_reg) begin
                res_status_reg <= ST_BUSY;
            end else if (!aligned_reg) begin
                if ({1'b0, roll_abs} <= {2'b00, home_tol_reg}) begin
                    res_status_reg <= ST_ALIGNED;
                end else begin
                    res_move_reg   <= 1'b1;
                    res_steps_reg  <= HOME_STEPS;
                    res_dir_reg    <= roll_pos;
                    res_status_reg <= ST_HOMING;
                end
            end else if (lux_sum < night_lux_reg) begin
                res_status_reg <= ST_DARK;
            end else if ({1'b0, roll_abs} > {2'b00, roll_lim_reg}) begin
                res_status_reg <= ST_LIMIT;
            end else begin
                res_status_reg <= ST_WAIT;
            end
        end

        if (state_reg == S_CHK) begin
            err_reg        <= err_calc;
            err_abs_reg    <= err_calc_abs;
            res_err_reg    <= err_calc;
            res_status_reg <= is_stable ? ST_STABLE : ST_DEADZONE;
        end

        if (state_reg == S_MUL) begin
            prod_reg <= {16'd0, err_abs_reg} * {16'd0, gain_reg};
        end

        if (state_reg == S_MOVE) begin
            res_move_reg   <= 1'b1;
            res_steps_reg  <= move_steps;
            res_dir_reg    <= move_dir;
            res_status_reg <= ST_MOVING;
            res_err_reg    <= err_reg;
        end

        if (state_reg == S_FIN && out_free) begin
            m_data_reg <= {6'd0, res_err_reg, res_dir_reg, res_steps_reg, res_move_reg};
            m_user_reg <= res_status_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

endmodule

>>> hw/rtl/stc_checker.sv
// Port-level assertion checker for the solar tracker step controller, with its bind.
`include "solar_tracker_step_controller_macros.svh"

module stc_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [stc_pkg::OUT_DATA_W-1:0]  m_tdata,
    input logic [stc_pkg::STATUS_W-1:0]    m_tuser
);
    import stc_pkg::*;

    `STC_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result beat changed while stalled")

    // One item at a time: ready drops right after an input beat.
    `STC_ASSERT_NEXT(a_one_item, aclk, aresetn, s_tvalid && s_tready,
        !s_tready, "input accepted while an item is in flight")

    `STC_ASSERT_SAME(a_idle_burst, aclk, aresetn, m_tvalid && !m_tdata[0],
        m_tdata[9:1] == 9'd0, "step count or direction set without a move")

    `STC_ASSERT_SAME(a_zero_err, aclk, aresetn,
        m_tvalid && (m_tuser == ST_HOMING || m_tuser == ST_ALIGNED || m_tuser == ST_DARK
        || m_tuser == ST_LIMIT || m_tuser == ST_WAIT || m_tuser == ST_BUSY
        || m_tuser == ST_NOCHECK),
        m_tdata[25:10] == 16'd0, "error reported on a status that carries none")

endmodule

bind solar_tracker_step_controller stc_checker u_stc_checker (.*);

>>> tb/solar_tracker_step_controller_tb.sv
// Self-checking testbench for the solar tracker step controller: directed and random beats.
`timescale 1ns / 1ps

module solar_tracker_step_controller_tb;
    import stc_pkg::*;

    localparam int              CLK_HALF    = 6;
    localparam int              CYCLE_LIMIT = 3_000_000;
    localparam int              DRAIN_WAIT  = 12;
    localparam logic [OP_W-1:0] OP_UNUSED   = 2'd3;

    typedef struct packed {
        logic              move;
        logic [STEP_W-1:0] steps;
        logic              dir;
        logic [STATUS_W-1:0] status;
        logic [ERR_W-1:0]  err;
    } motor_cmd_t;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_DATA_W-1:0]   s_tdata = '0;
    logic [OP_W-1:0]        s_tuser = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_DATA_W-1:0]  m_tdata;
    logic [STATUS_W-1:0]    m_tuser;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_DAT_W-1:0]   cfg_data = '0;

    // Tracker copy: configuration
    int gain_r, deadzone_r, change_r, min_vgain_r;
    int roll_lim_r, home_tol_r, interval_r, night_lux_r;
    // Tracker copy: state
    bit tracker_aligned, check_pending, pend_dir;
    int last_err, secs_idle, pend_steps, pend_err, volt_before;

    motor_cmd_t expected_cmds[$];
    bit         idle_en = 1'b0;
    int         cycle_count = 0;
    int         fail_count = 0;
    int         items_sent = 0;
    int         results_seen = 0;
    int         config_sets = 0;
    int         status_hits[16];

    solar_tracker_step_controller uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #CLK_HALF aclk = ~aclk;

    always @(posedge aclk) begin
        m_tready <= !(idle_en && $urandom_range(99) < 7);
    end

    function automatic int abs_int(input int v);
        return v < 0 ? -v : v;
    endfunction

    // Advance the tracker copy by one beat; return 1 when a result is due.
    function automatic bit plan_motor_cmd(input logic [OP_W-1:0] op, input int lux_l,
                                          input int lux_r, input int bus, input int roll,
                                          output motor_cmd_t cmd);
        int     err;
        int     sum;
        int     diff;
        longint mag;
        longint prod;
        cmd = '0;
        case (op)
            OP_TICK: begin
                if (secs_idle < 65535) secs_idle++;
                return 1'b0;
            end
            OP_CHECK: begin
                if (!check_pending) begin
                    cmd.status = ST_NOCHECK;
                    return 1'b1;
                end
                check_pending = 1'b0;
                cmd.err = ERR_W'(pend_err);
                if (bus - volt_before < min_vgain_r) begin
                    cmd.move   = 1'b1;
                    cmd.steps  = STEP_W'(pend_steps);
                    cmd.dir    = !pend_dir;
                    cmd.status = ST_REVERTED;
                end else begin
                    last_err   = pend_err;
                    secs_idle  = 0;
                    cmd.status = ST_EFFECTIVE;
                end
                return 1'b1;
            end
            OP_TRACK: begin
                if (check_pending) begin
                    cmd.status = ST_BUSY;
                    return 1'b1;
                end
                if (!tracker_aligned) begin
                    if (abs_int(roll) <= home_tol_r) begin
                        tracker_aligned = 1'b1;
                        secs_idle  = 0;
                        cmd.status = ST_ALIGNED;
                    end else begin
                        cmd.move   = 1'b1;
                        cmd.steps  = HOME_STEPS_DEF;
                        cmd.dir    = roll > 0;
                        cmd.status = ST_HOMING;
                    end
                    return 1'b1;
                end
                if (lux_l + lux_r < night_lux_r) begin
                    cmd.status = ST_DARK;
                    return 1'b1;
                end
                if (abs_int(roll) > roll_lim_r) begin
                    cmd.status = ST_LIMIT;
                    return 1'b1;
                end
                if (secs_idle < interval_r) begin
                    cmd.status = ST_WAIT;
                    return 1'b1;
                end
                sum  = lux_l + lux_r;
                diff = abs_int(lux_r - lux_l);
                if (sum == 0) begin
                    err = 0;
                end else begin
                    mag = (longint'(diff) << 15) / sum;
                    if (lux_r >= lux_l) err = (mag > 32767) ? 32767 : int'(mag);
                    else err = -int'(mag);
                end
                cmd.err = ERR_W'(err);
                if (abs_int(err - last_err) < change_r) begin
                    cmd.status = ST_STABLE;
                    return 1'b1;
                end
                if (abs_int(err) < deadzone_r) begin
                    cmd.status = ST_DEADZONE;
                    return 1'b1;
                end
                prod = (longint'(abs_int(err)) * gain_r) >> 15;
                if (prod > MAX_STEPS_DEF) prod = MAX_STEPS_DEF;
                check_pending = 1'b1;
                pend_steps    = int'(prod);
                pend_dir      = err > 0;
                pend_err      = err;
                volt_before   = bus;
                cmd.move      = 1'b1;
                cmd.steps     = STEP_W'(prod);
                cmd.dir       = err > 0;
                cmd.status    = ST_MOVING;
                return 1'b1;
            end
            default: return 1'b0;
        endcase
    endfunction

    function automatic int rand_lux();
        case ($urandom_range(9))
            0: return 0;
            1: return 65535;
            2: return $urandom_range(0, 100);
            default: return $urandom_range(0, 65535);
        endcase
    endfunction

    function automatic int rand_bus();
        case ($urandom_range(9))
            0: return 0;
            1: return 32767;
            default: return $urandom_range(0, 32767);
        endcase
    endfunction

    function automatic int rand_roll();
        int r;
        int lim;
        r   = $urandom_range(9);
        lim = roll_lim_r + 50;
        if (lim > 32767) lim = 32767;
        if (r == 0) return -32768;
        if (r == 1) return 32767;
        if (r < 4) return int'($signed(16'($urandom())));
        return int'($urandom_range(0, 2 * lim)) - lim;
    endfunction

    task automatic send_item(input logic [OP_W-1:0] op, input int lux_l, input int lux_r,
                             input int bus, input int roll);
        motor_cmd_t       cmd;
        logic [15:0]      l16;
        logic [15:0]      r16;
        logic [14:0]      b15;
        logic signed [15:0] roll16;
        l16    = lux_l[15:0];
        r16    = lux_r[15:0];
        b15    = bus[14:0];
        roll16 = roll[15:0];
        while (idle_en && $urandom_range(99) < 7) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tuser  <= op;
        s_tdata  <= {1'b0, roll16, b15, r16, l16};
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        if (plan_motor_cmd(op, int'(l16), int'(r16), int'(b15), int'(roll16), cmd))
            expected_cmds.push_back(cmd);
        if (op != OP_UNUSED) items_sent++;
    endtask

    // Drop valid and hold until every result is back and the block is idle.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (expected_cmds.size() != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
        cfg_index <= idx;
        cfg_data  <= value[CFG_DAT_W-1:0];
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_GAIN:      gain_r      = int'(value[15:0]);
            CFG_DEADZONE:  deadzone_r  = int'(value[14:0]);
            CFG_CHANGE:    change_r    = int'(value[14:0]);
            CFG_MIN_VGAIN: min_vgain_r = int'(value[14:0]);
            CFG_ROLL_LIM:  roll_lim_r  = int'(value[14:0]);
            CFG_HOME_TOL:  home_tol_r  = int'(value[14:0]);
            CFG_INTERVAL:  interval_r  = int'(value[15:0]);
            CFG_NIGHT_LUX: night_lux_r = int'(value[16:0]);
            default: ;
        endcase
        @(posedge aclk);
    endtask

    task automatic set_config(input int g, input int dz, input int ch, input int mv,
                              input int rl, input int ht, input int iv, input int nl);
        write_reg(CFG_GAIN, g);
        write_reg(CFG_DEADZONE, dz);
        write_reg(CFG_CHANGE, ch);
        write_reg(CFG_MIN_VGAIN, mv);
        write_reg(CFG_ROLL_LIM, rl);
        write_reg(CFG_HOME_TOL, ht);
        write_reg(CFG_INTERVAL, iv);
        write_reg(CFG_NIGHT_LUX, nl);
        config_sets++;
    endtask

    task automatic test_homing();
        send_item(OP_CHECK, 0, 0, 0, 0);
        send_item(OP_TRACK, 500, 500, 0, 101);
        send_item(OP_TRACK, 500, 500, 0, -32768);
        send_item(OP_TRACK, 0, 0, 0, 32767);
        send_item(OP_TICK, 65535, 0, 32767, -1);
        send_item(OP_UNUSED, 65535, 65535, 32767, -1);
        wait_idle();
        write_reg(CFG_HOME_TOL, 0);
        send_item(OP_TRACK, 100, 100, 100, 1);
        send_item(OP_TRACK, 100, 100, 100, -1);
        send_item(OP_TRACK, 100, 100, 100, 0);
        // aligned now: dark, roll limit, then move interval not yet run out
        send_item(OP_TRACK, 10, 20, 100, 0);
        send_item(OP_TRACK, 25, 25, 100, 4501);
        send_item(OP_TRACK, 25, 25, 100, -4500);
    endtask

    task automatic test_move_check();
        wait_idle();
        set_config(0, 0, 0, 50, 4500, 0, 0, 0);
        // zero lux sum and a burst of zero steps
        send_item(OP_TRACK, 0, 0, 200, 0);
        send_item(OP_TRACK, 300, 100, 200, 0);
        send_item(OP_CHECK, 0, 0, 249, 0);
        send_item(OP_CHECK, 0, 0, 249, 0);
        wait_idle();
        write_reg(CFG_GAIN, 65535);
        send_item(OP_TRACK, 0, 65535, 1000, 0);
        send_item(OP_CHECK, 0, 0, 1050, 0);
        send_item(OP_TRACK, 65535, 0, 32767, 0);
        send_item(OP_CHECK, 0, 0, 0, 0);
    endtask

    task automatic test_thresholds();
        wait_idle();
        set_config(65535, 32767, 32767, 32767, 0, 0, 0, 0);
        send_item(OP_TRACK, 0, 0, 0, 0);
        send_item(OP_TRACK, 1000, 1001, 0, 0);
        send_item(OP_TRACK, 1000, 1001, 0, 1);
        wait_idle();
        write_reg(CFG_NIGHT_LUX, 131071);
        send_item(OP_TRACK, 65535, 65535, 0, 0);
    endtask

    task automatic test_random_tracking();
        int phase_len[6] = '{150, 100, 40, 150, 140, 140};
        int start;
        int lux_l;
        int lux_r;
        int bus;
        int need;
        int op_sel;
        for (int phase = 0; phase < 6; phase++) begin
            wait_idle();
            idle_en = (phase != 0);
            case (phase)
                0: set_config(800, 1638, 3277, 50, 4500, 100, 3, 50);
                1: set_config(0, 0, 0, 0, 0, 0, 0, 0);
                2: set_config(65535, 32767, 0, 32767, 32767, 32767, 0, 0);
                default: set_config($urandom_range(0, 65535), $urandom_range(0, 4000),
                                    $urandom_range(0, 6000), $urandom_range(0, 300),
                                    $urandom_range(0, 18000), $urandom_range(0, 18000),
                                    $urandom_range(0, 8), $urandom_range(0, 3000));
            endcase
            start = items_sent;
            while (items_sent - start < phase_len[phase]) begin
                if ($urandom_range(99) < 60) begin
                    // well-formed run: clear a pending check, tick out the interval,
                    // take a sample and usually confirm it
                    if (check_pending) send_item(OP_CHECK, rand_lux(), rand_lux(), rand_bus(), 0);
                    need = interval_r - secs_idle;
                    if (need <= 0 || need > 12) need = $urandom_range(0, 2);
                    repeat (need) send_item(OP_TICK, rand_lux(), rand_lux(), rand_bus(), 0);
                    if ($urandom_range(1) == 0) begin
                        lux_l = $urandom_range(200, 60000);
                        lux_r = lux_l + int'($urandom_range(0, 400)) - 200;
                    end else begin
                        lux_l = rand_lux();
                        lux_r = rand_lux();
                    end
                    send_item(OP_TRACK, lux_l, lux_r, rand_bus(), rand_roll());
                    if (check_pending && $urandom_range(9) < 8) begin
                        if ($urandom_range(3) == 0) begin
                            bus = rand_bus();
                        end else begin
                            bus = volt_before + min_vgain_r + int'($urandom_range(0, 6)) - 3;
                            if (bus < 0) bus = 0;
                            if (bus > 32767) bus = 32767;
                        end
                        send_item(OP_CHECK, rand_lux(), rand_lux(), bus, rand_roll());
                    end
                end else begin
                    op_sel = $urandom_range(0, 3);
                    send_item(OP_W'(op_sel), rand_lux(), rand_lux(), rand_bus(), rand_roll());
                end
            end
        end
    endtask

    // Seconds counter against the move interval: one tick short, then exactly on it.
    task automatic test_interval_edge();
        wait_idle();
        idle_en = 1'b0;
        set_config(800, 0, 0, 50, 32767, 100, 20, 0);
        if (check_pending) send_item(OP_CHECK, 0, 0, 0, 0);
        send_item(OP_TRACK, 100, 900, 0, 0);
        if (check_pending) send_item(OP_CHECK, 0, 0, 32767, 0);
        repeat (19) send_item(OP_TICK, 0, 0, 0, 0);
        send_item(OP_TRACK, 900, 100, 0, 0);
        send_item(OP_TICK, 0, 0, 0, 0);
        send_item(OP_TRACK, 900, 100, 0, 0);
        send_item(OP_CHECK, 0, 0, 32767, 0);
    endtask

    always @(posedge aclk) begin : check_result
        motor_cmd_t want;
        if (aresetn && m_tvalid && m_tready) begin
            results_seen++;
            status_hits[m_tuser]++;
            if (expected_cmds.size() == 0) begin
                fail_count++;
                if (fail_count <= 10)
                    $display("%0t: result with nothing pending: status %0d data %h",
                             $time, m_tuser, m_tdata);
            end else begin
                want = expected_cmds.pop_front();
                if (m_tdata[0] !== want.move || m_tdata[8:1] !== want.steps ||
                    m_tdata[9] !== want.dir || m_tuser !== want.status ||
                    m_tdata[25:10] !== want.err) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display({"%0t: mismatch: expected move %0d steps %0d dir %0d ",
                                  "status %0d err %0d, got move %0d steps %0d dir %0d ",
                                  "status %0d err %0d"},
                                 $time, want.move, want.steps, want.dir, want.status,
                                 $signed(want.err), m_tdata[0], m_tdata[8:1], m_tdata[9],
                                 m_tuser, $signed(m_tdata[25:10]));
                end
            end
        end
    end

    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("Timeout after %0d cycles, %0d results outstanding",
                 cycle_count, expected_cmds.size());
        $display("CHECK FAILED");
        $finish;
    end

    initial begin : run_tests
        int codes_seen;
        gain_r      = int'(GAIN_RST);
        deadzone_r  = int'(DEADZONE_RST);
        change_r    = int'(CHANGE_RST);
        min_vgain_r = int'(MIN_VGAIN_RST);
        roll_lim_r  = int'(ROLL_LIM_RST);
        home_tol_r  = int'(HOME_TOL_RST);
        interval_r  = int'(INTERVAL_RST);
        night_lux_r = int'(NIGHT_LUX_RST);
        tracker_aligned = 1'b0;
        check_pending = 1'b0;
        pend_dir      = 1'b0;
        last_err      = 0;
        secs_idle     = 0;
        pend_steps    = 0;
        pend_err      = 0;
        volt_before   = 0;
        foreach (status_hits[i]) status_hits[i] = 0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        idle_en = 1'b1;

        test_homing();
        test_move_check();
        test_thresholds();
        test_random_tracking();
        test_interval_edge();

        wait_idle();
        if (expected_cmds.size() != 0) fail_count++;
        codes_seen = 0;
        for (int i = 0; i <= ST_NOCHECK; i++) if (status_hits[i] != 0) codes_seen++;
        $display("Summary: %0d beats sent, %0d results checked, %0d of 12 status codes hit",
                 items_sent, results_seen, codes_seen);
        $display("Summary: %0d register sets applied, %0d mismatches, %0d cycles",
                 config_sets, fail_count, cycle_count);
        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

>>> filelist.f
+incdir+hw/rtl
hw/rtl/stc_pkg.sv
hw/rtl/stc_div.sv
hw/rtl/solar_tracker_step_controller.sv
hw/rtl/stc_checker.sv
tb/solar_tracker_step_controller_tb.sv
